FILE: src/lslfe_pkg.sv
// ----------------------------------------------------------------------------
// lslfe_pkg: shared types and codes for the least-squares line fit block
// Input and result beat structs, fit status codes, controller commands.
// ----------------------------------------------------------------------------
package lslfe_pkg;

  localparam int unsigned CoordW = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] x_coord;
    logic signed [CoordW-1:0] y_coord;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [47:0]        energy;
    logic [1:0]         fit_status;
    logic               points_dropped;
  } result_t;

  localparam logic [1:0] StatusFitted = 2'd0;
  localparam logic [1:0] StatusFew    = 2'd1;
  localparam logic [1:0] StatusDegen  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // take a point beat
    logic prod_go;   // start product pass
    logic div_go;    // start one division
    logic div_sel;   // 0 slope, 1 intercept
    logic sqrt_go;
    logic walk_go;
    logic finish;    // present result and clear set
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic prod_done;
    logic div_done;
    logic sqrt_done;
    logic walk_done;
    logic few;
    logic degen;
  } dp_sts_t;

endpackage

FILE: src/lslfe_ram.sv
// ----------------------------------------------------------------------------
// lslfe_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lslfe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: src/lslfe_ctrl.sv
// ----------------------------------------------------------------------------
// lslfe_ctrl: sequencer for the fit
// Steps through load, products, slope and intercept divides (skipped if the
// set is few or degenerate), square root, distance walk, then one result beat.
// ----------------------------------------------------------------------------
module lslfe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               last_i,
  input  lslfe_pkg::dp_sts_t sts_i,
  output lslfe_pkg::dp_cmd_t cmd_o,
  output logic               busy_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StProd  = 4'd1;
  localparam logic [3:0] StPrdW  = 4'd2;
  localparam logic [3:0] StDivS  = 4'd3;
  localparam logic [3:0] StDivSW = 4'd4;
  localparam logic [3:0] StDivB  = 4'd5;
  localparam logic [3:0] StDivBW = 4'd6;
  localparam logic [3:0] StSqrt  = 4'd7;
  localparam logic [3:0] StSqrtW = 4'd8;
  localparam logic [3:0] StWalk  = 4'd9;
  localparam logic [3:0] StWalkW = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) state_d = StProd;
        end
      end
      StProd: begin
        cmd_o.prod_go = 1'b1;
        state_d = StPrdW;
      end
      StPrdW: begin
        if (sts_i.prod_done) begin
          if (sts_i.few || sts_i.degen) state_d = StSqrt;
          else state_d = StDivS;
        end
      end
      StDivS: begin
        cmd_o.div_go = 1'b1;
        state_d = StDivSW;
      end
      StDivSW: begin
        if (sts_i.div_done) state_d = StDivB;
      end
      StDivB: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = 1'b1;
        state_d = StDivBW;
      end
      StDivBW: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) state_d = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_go = 1'b1;
        state_d = StSqrtW;
      end
      StSqrtW: begin
        if (sts_i.sqrt_done) state_d = StWalk;
      end
      StWalk: begin
        cmd_o.walk_go = 1'b1;
        state_d = StWalkW;
      end
      StWalkW: begin
        if (sts_i.walk_done) state_d = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/lslfe_dp.sv
// ----------------------------------------------------------------------------
// lslfe_dp: datapath of the line fit
// Point store, running sums, 128-bit product sequencer, restoring divider
// shared by slope, intercept and distances, and a bit-pair square root.
// ----------------------------------------------------------------------------
module lslfe_dp #(
  parameter int unsigned MaxPoints = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lslfe_pkg::point_t   pt_i,
  input  lslfe_pkg::dp_cmd_t  cmd_i,
  output lslfe_pkg::dp_sts_t  sts_o,
  output logic                done_o,
  output lslfe_pkg::result_t  res_o
);

  localparam int unsigned CoordBits = lslfe_pkg::CoordW;
  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned SumW  = CoordBits + CntW;
  localparam int unsigned PSumW = 2 * CoordBits + CntW;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPoints);

  // ---------------- input and store
  logic signed [CoordBits-1:0] x_in, y_in;
  assign x_in = pt_i.x_coord[CoordBits-1:0];
  assign y_in = pt_i.y_coord[CoordBits-1:0];

  logic [CntW-1:0]  cnt_q;
  logic             ovf_q;
  logic signed [SumW-1:0]  sx_q, sy_q;
  logic signed [PSumW-1:0] sxy_q, sxx_q;
  logic signed [31:0] slope_q, icpt_q;
  logic             store_we;
  logic [AddrW-1:0] ram_addr, walk_idx_q;
  logic [2*CoordBits-1:0] ram_rd;

  assign store_we = cmd_i.load && (cnt_q != CntMax);
  assign ram_addr = cmd_i.load ? cnt_q[AddrW-1:0] : walk_idx_q;

  lslfe_ram #(.Width(2 * CoordBits), .Depth(MaxPoints)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (ram_addr),
    .wdata_i ({x_in, y_in}),
    .rdata_o (ram_rd)
  );

  // product of input pair, combinational, added into the sums
  logic signed [2*CoordBits-1:0] pxy, pxx;
  assign pxy = x_in * y_in;
  assign pxx = x_in * x_in;

  // ---------------- wide product sequencer: 6 products, 32x32 per cycle
  // operands are up to 64 bits signed; each product takes 4 partial steps
  logic signed [127:0] den_q, sn_q, bn_q;
  logic signed [127:0] acc_q;
  logic [63:0] opa_q, opb_q;
  logic        neg_q;
  logic [2:0]  pidx_q;
  logic [1:0]  part_q;
  logic        prod_run_q, prod_done_q;

  logic signed [63:0] n64, sx64, sy64, sxy64, sxx64;
  assign n64   = 64'(cnt_q);
  assign sx64  = 64'(sx_q);
  assign sy64  = 64'(sy_q);
  assign sxy64 = 64'(sxy_q);
  assign sxx64 = 64'(sxx_q);

  function automatic logic [63:0] mag_sel(input logic [2:0] idx, input logic side);
    logic signed [63:0] v;
    case (idx)
      3'd0: v = side ? sxx64 : n64;
      3'd1: v = sx64;
      3'd2: v = side ? sxy64 : n64;
      3'd3: v = side ? sy64 : sx64;
      3'd4: v = side ? sxx64 : sy64;
      3'd5: v = side ? sxy64 : sx64;
      default: v = '0;
    endcase
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic neg_sel(input logic [2:0] idx);
    logic signed [63:0] a, b;
    case (idx)
      3'd0: begin a = n64;  b = sxx64; end
      3'd1: begin a = sx64; b = sx64;  end
      3'd2: begin a = n64;  b = sxy64; end
      3'd3: begin a = sx64; b = sy64;  end
      3'd4: begin a = sy64; b = sxx64; end
      3'd5: begin a = sx64; b = sxy64; end
      default: begin a = '0; b = '0; end
    endcase
    return a[63] ^ b[63];
  endfunction

  logic [31:0]  pa, pb;
  logic [63:0]  pp_q;
  logic [127:0] pp_sh;
  logic         pp_v_q;
  logic [1:0]   pp_part_q;
  logic         pp_last_q;
  assign pa = part_q[0] ? opa_q[63:32] : opa_q[31:0];
  assign pb = part_q[1] ? opb_q[63:32] : opb_q[31:0];
  always_comb begin
    pp_sh = 128'(pp_q);
    case (pp_part_q)
      2'd1, 2'd2: pp_sh = pp_sh << 32;
      2'd3:       pp_sh = pp_sh << 64;
      default:    pp_sh = 128'(pp_q);
    endcase
  end

  logic [127:0] prod_u_d;
  logic signed [127:0] prod_s;
  assign prod_u_d = acc_q + pp_sh;
  assign prod_s   = neg_q ? -$signed(prod_u_d) : $signed(prod_u_d);

  // ---------------- shared divider: 128-bit numerator, 128-bit divisor
  logic [127:0] dn_q, dd_q, dq_q, drem_q;
  logic [7:0]   dcnt_q;
  logic         drun_q, ddone_q;
  logic [128:0] dtrial;
  logic [127:0] drem_sh;
  assign drem_sh = {drem_q[126:0], dn_q[127]};
  assign dtrial  = {1'b0, drem_sh} - {1'b0, dd_q};

  // divider source: fit ratio or distance
  logic         div_neg_q;
  logic         walk_q;

  // ---------------- square root
  logic [63:0] sq_s_q, sq_res_q, sq_bit_q;
  logic        sq_run_q, sq_done_q;
  logic [63:0] sq_rb;
  assign sq_rb = sq_res_q + sq_bit_q;

  // ---------------- walk
  logic [CntW-1:0] walk_n_q;
  logic [1:0]      wph_q;   // 0 read, 1 data, 2 distance, 3 wait divide
  logic            walk_done_q;
  logic [48:0]     energy_q;
  logic [1:0]      status_q;

  logic signed [CoordBits-1:0] rx, ry;
  assign rx = ram_rd[2*CoordBits-1:CoordBits];
  assign ry = ram_rd[CoordBits-1:0];
  logic signed [63:0] tprod_q;
  logic signed [CoordBits-1:0] ry_q;
  logic signed [63:0] tval;
  assign tval = tprod_q + 64'(icpt_q) - (64'(ry_q) <<< 16);
  logic [63:0] tmag;
  assign tmag = tval[63] ? 64'(-tval) : 64'(tval);

  // quotient saturation for fit ratios
  logic [31:0] sat_mag;
  logic        sat_over;
  assign sat_over = div_neg_q ? (dq_q > 128'h8000_0000) : (dq_q > 128'h7fff_ffff);
  assign sat_mag  = sat_over ? (div_neg_q ? 32'h8000_0000 : 32'h7fff_ffff) : dq_q[31:0];

  logic [48:0] e_next;
  assign e_next = energy_q + 49'(dq_q[47:0]);

  assign sts_o.prod_done = prod_done_q;
  assign sts_o.div_done  = ddone_q;
  assign sts_o.sqrt_done = sq_done_q;
  assign sts_o.walk_done = walk_done_q;
  assign sts_o.few       = (cnt_q < CntW'(2));
  assign sts_o.degen     = (den_q == '0);

  // slope magnitude fits 32 bits, so its square is a 32x32 product
  logic [31:0] smag;
  assign smag = slope_q[31] ? 32'(-slope_q) : 32'(slope_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      sxx_q       <= '0;
      slope_q     <= '0;
      icpt_q      <= '0;
      prod_run_q  <= 1'b0;
      prod_done_q <= 1'b0;
      pp_v_q      <= 1'b0;
      drun_q      <= 1'b0;
      ddone_q     <= 1'b0;
      sq_run_q    <= 1'b0;
      sq_done_q   <= 1'b0;
      walk_q      <= 1'b0;
      walk_done_q <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      prod_done_q <= 1'b0;
      ddone_q     <= 1'b0;
      sq_done_q   <= 1'b0;
      walk_done_q <= 1'b0;
      done_o      <= 1'b0;

      if (cmd_i.load) begin
        if (store_we) begin
          cnt_q <= cnt_q + 1'b1;
          sx_q  <= sx_q + SumW'(x_in);
          sy_q  <= sy_q + SumW'(y_in);
          sxy_q <= sxy_q + PSumW'(pxy);
          sxx_q <= sxx_q + PSumW'(pxx);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      // product pass: register each partial, accumulate it in the next cycle
      if (cmd_i.prod_go) begin
        prod_run_q <= 1'b1;
        pidx_q     <= 3'd0;
        part_q     <= 2'd0;
        acc_q      <= '0;
        pp_v_q     <= 1'b0;
        opa_q      <= n64[63] ? 64'(-n64) : 64'(n64);
        opb_q      <= sxx64[63] ? 64'(-sxx64) : 64'(sxx64);
        neg_q      <= n64[63] ^ sxx64[63];
      end else if (prod_run_q) begin
        pp_q      <= pa * pb;
        pp_part_q <= part_q;
        pp_last_q <= (part_q == 2'd3);
        if (pp_v_q && pp_last_q) begin
          // product complete
          case (pidx_q)
            3'd0: den_q <= prod_s;
            3'd1: den_q <= den_q - prod_s;
            3'd2: sn_q  <= prod_s;
            3'd3: sn_q  <= sn_q - prod_s;
            3'd4: bn_q  <= prod_s;
            3'd5: bn_q  <= bn_q - prod_s;
            default: ;
          endcase
          acc_q  <= '0;
          pp_v_q <= 1'b0;
          if (pidx_q == 3'd5) begin
            prod_run_q  <= 1'b0;
            prod_done_q <= 1'b1;
          end else begin
            pidx_q <= pidx_q + 1'b1;
            opa_q  <= mag_sel(pidx_q + 1'b1, 1'b0);
            opb_q  <= mag_sel(pidx_q + 1'b1, 1'b1);
            neg_q  <= neg_sel(pidx_q + 1'b1);
            part_q <= 2'd0;
          end
        end else begin
          pp_v_q <= 1'b1;
          if (pp_v_q) acc_q <= prod_u_d;
          // hold the top partial until it is accumulated
          if (part_q != 2'd3) part_q <= part_q + 1'b1;
        end
      end

      // divider start
      if (cmd_i.div_go) begin
        div_neg_q <= cmd_i.div_sel ? bn_q[127] : sn_q[127];
        dn_q      <= (cmd_i.div_sel ? (bn_q[127] ? 128'(-bn_q) : 128'(bn_q))
                                    : (sn_q[127] ? 128'(-sn_q) : 128'(sn_q))) << 16;
        dd_q      <= den_q;
        drem_q    <= '0;
        dq_q      <= '0;
        dcnt_q    <= 8'd0;
        drun_q    <= 1'b1;
      end else if (drun_q) begin
        if (!dtrial[128]) begin
          drem_q <= dtrial[127:0];
          dq_q   <= {dq_q[126:0], 1'b1};
        end else begin
          drem_q <= drem_sh;
          dq_q   <= {dq_q[126:0], 1'b0};
        end
        dn_q   <= dn_q << 1;
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == 8'd127) begin
          drun_q  <= 1'b0;
          ddone_q <= !walk_q;
        end
      end
      if (ddone_q && !walk_q) begin
        if (cmd_i.div_sel) icpt_q <= div_neg_q ? -sat_mag : sat_mag;
        else slope_q <= div_neg_q ? -sat_mag : sat_mag;
      end

      // square root, two bits a step
      if (cmd_i.sqrt_go) begin
        sq_s_q   <= smag * smag + 64'h1_0000_0000;
        sq_res_q <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
        sq_run_q <= 1'b1;
      end else if (sq_run_q) begin
        if (sq_s_q >= sq_rb) begin
          sq_s_q   <= sq_s_q - sq_rb;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        if (sq_bit_q == 64'd1) begin
          sq_run_q  <= 1'b0;
          sq_done_q <= 1'b1;
        end
      end

      // distance walk
      if (cmd_i.walk_go) begin
        walk_q     <= 1'b1;
        walk_idx_q <= '0;
        walk_n_q   <= '0;
        wph_q      <= 2'd0;
        energy_q   <= '0;
        status_q   <= (cnt_q < CntW'(2)) ? lslfe_pkg::StatusFew :
                      (den_q == '0) ? lslfe_pkg::StatusDegen : lslfe_pkg::StatusFitted;
      end else if (walk_q) begin
        case (wph_q)
          2'd0: begin
            if (walk_n_q == cnt_q) begin
              walk_q      <= 1'b0;
              walk_done_q <= 1'b1;
            end else begin
              wph_q <= 2'd1;
            end
          end
          2'd1: begin
            tprod_q <= 64'(slope_q) * 64'(rx);
            ry_q    <= ry;
            wph_q   <= 2'd2;
          end
          2'd2: begin
            dn_q   <= 128'(tmag) << 16;
            dd_q   <= 128'(sq_res_q);
            drem_q <= '0;
            dq_q   <= '0;
            dcnt_q <= 8'd0;
            drun_q <= 1'b1;
            wph_q  <= 2'd3;
          end
          2'd3: begin
            if (!drun_q) begin
              energy_q   <= e_next[48] || e_next[47:0] == '1 ?
                            49'h0_ffff_ffff_ffff : e_next;
              walk_n_q   <= walk_n_q + 1'b1;
              walk_idx_q <= walk_idx_q + 1'b1;
              wph_q      <= 2'd0;
            end
          end
          default: wph_q <= 2'd0;
        endcase
      end

      if (cmd_i.finish) begin
        done_o <= 1'b1;
        res_o.slope          <= slope_q;
        res_o.intercept      <= icpt_q;
        res_o.energy         <= energy_q[47:0];
        res_o.fit_status     <= status_q;
        res_o.points_dropped <= ovf_q;
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
        sxx_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

endmodule

FILE: src/least_squares_line_fit_energy.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_energy: least-squares line fit with distance energy
// Stores a set of points, fits y = a*x + b in Q16.16 and sums perpendicular
// distances of the stored points to the line.
//
//   channel | signals                     | direction
//   point   | start, busy, point_i        | in
//   result  | done_o, result_o            | out
//
// A point that is not last is stored and summed. The last point starts the
// fit: 32x32 partial products, two 128-step divides unless the set is few
// or degenerate, 32 square root steps, then one divide per stored point by
// the shared restoring divider. busy holds off points for the whole fit;
// the receiver cannot stall. Reset clears counts, sums and the line; the
// point store needs no clearing. The result is a one-cycle strobe on done_o.
// ----------------------------------------------------------------------------
module least_squares_line_fit_energy #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lslfe_pkg::point_t   point_i,
  output logic                done_o,
  output lslfe_pkg::result_t  result_o
);

  lslfe_pkg::dp_cmd_t cmd;
  lslfe_pkg::dp_sts_t sts;
  logic start_ok;

  assign start_ok = start && !busy;

  lslfe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_ok),
    .last_i  (point_i.last_point),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lslfe_dp #(.MaxPoints(MAX_POINTS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (point_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (result_o)
  );

endmodule

FILE: src/lslfe_chk.sv
// ----------------------------------------------------------------------------
// lslfe_chk: port checker for the line fit block
// Watches the handshake and result beats on the top level ports.
// ----------------------------------------------------------------------------
module lslfe_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input lslfe_pkg::point_t  point_i,
  input logic               done_o,
  input lslfe_pkg::result_t result_o
);

  // a last point always makes the block busy next cycle
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && point_i.last_point |=> busy)
    else $error("last point did not start fit");

  // result beat is a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without fit");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.fit_status <= lslfe_pkg::StatusDegen)
    else $error("bad status");

endmodule

bind least_squares_line_fit_energy lslfe_chk u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .point_i  (point_i),
  .done_o   (done_o),
  .result_o (result_o)
);

FILE: tb/sv/lslfe_checker.sv
// ----------------------------------------------------------------------------
// lslfe_checker: scoreboard for the least-squares line fit block
// Watches point and result beats, predicts each fit result from its own copy
// of the point set, sums and line, and compares result beats field by field.
// ----------------------------------------------------------------------------
module lslfe_checker #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  lslfe_pkg::point_t   point_i,
  input  logic                done_o,
  input  lslfe_pkg::result_t  result_o,
  output int                  fail_count_o,
  output int                  pending_o
);

  longint    set_x [MAX_POINTS];
  longint    set_y [MAX_POINTS];
  int        set_n;
  longint    acc_x, acc_y, acc_xy, acc_xx;
  logic signed [31:0] cur_slope, cur_icpt;
  logic      dropped;
  lslfe_pkg::result_t fit_q[$];
  int        n_pend;
  int        mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = n_pend;

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q16.16 of num/den, truncated toward zero and saturated; den > 0
  function automatic logic signed [31:0] q16_div(logic signed [127:0] num,
                                                 logic signed [127:0] den);
    logic          neg;
    logic [127:0]  m, q, lim;
    neg = num < 0;
    m   = neg ? -num : num;
    q   = (m << 16) / den;
    lim = neg ? (128'd1 << 31) : (128'd1 << 31) - 1;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic lslfe_pkg::result_t fit_set();
    lslfe_pkg::result_t  res;
    logic signed [127:0] n, den, sn, bn;
    logic [63:0]         mag, r;
    logic [127:0]        tm, e;
    longint              t;
    res = '0;
    res.fit_status = lslfe_pkg::StatusFitted;
    if (set_n < 2) begin
      res.fit_status = lslfe_pkg::StatusFew;
    end else begin
      n   = set_n;
      den = n * acc_xx - 128'(acc_x) * acc_x;
      if (den == 0) begin
        res.fit_status = lslfe_pkg::StatusDegen;
      end else begin
        sn = n * acc_xy - 128'(acc_x) * acc_y;
        bn = 128'(acc_y) * acc_xx - 128'(acc_x) * acc_xy;
        cur_slope = q16_div(sn, den);
        cur_icpt  = q16_div(bn, den);
      end
    end
    mag = cur_slope < 0 ? 64'(-longint'(cur_slope)) : 64'(cur_slope);
    r = root64(mag * mag + (64'd1 << 32));
    e = 0;
    for (int i = 0; i < set_n; i++) begin
      t  = longint'(cur_slope) * set_x[i] + longint'(cur_icpt) - set_y[i] * 65536;
      tm = t < 0 ? 128'(-t) : 128'(t);
      e  = e + (tm << 16) / r;
      if (e > (128'd1 << 48) - 1) e = (128'd1 << 48) - 1;
    end
    res.slope          = cur_slope;
    res.intercept      = cur_icpt;
    res.energy         = e[47:0];
    res.points_dropped = dropped;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_n = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
      cur_slope = 0; cur_icpt = 0; dropped = 0;
      mismatches = 0;
      n_pend = 0;
      fit_q.delete();
    end else begin
      if (done_o) begin
        if (n_pend == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with none expected: %p", result_o);
        end else begin
          lslfe_pkg::result_t exp_r;
          exp_r = fit_q.pop_front();
          n_pend--;
          if (result_o !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"fit mismatch (exp/act): slope %0d/%0d icpt %0d/%0d",
                        " energy %0d/%0d st %0d/%0d dr %0d/%0d"},
                       exp_r.slope, result_o.slope, exp_r.intercept, result_o.intercept,
                       exp_r.energy, result_o.energy, exp_r.fit_status,
                       result_o.fit_status, exp_r.points_dropped,
                       result_o.points_dropped);
          end
        end
      end
      if (start && !busy) begin
        if (set_n < MAX_POINTS) begin
          set_x[set_n] = point_i.x_coord;
          set_y[set_n] = point_i.y_coord;
          acc_x  += set_x[set_n];
          acc_y  += set_y[set_n];
          acc_xy += set_x[set_n] * set_y[set_n];
          acc_xx += set_x[set_n] * set_x[set_n];
          set_n++;
        end else begin
          dropped = 1;
        end
        if (point_i.last_point) begin
          fit_q.push_back(fit_set());
          n_pend++;
          set_n = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
          dropped = 0;
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the least-squares line fit block
// Sends directed and random point sets with random gaps; the checker beside
// the block predicts and compares every fit result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MaxPts = 256;
  localparam longint CycleLimit = 3000000;

  logic    clk_i, rst_ni, start, busy, done_o;
  lslfe_pkg::point_t  point_i;
  lslfe_pkg::result_t result_o;
  int      fail_count, pending, n_items, n_sets;
  longint  cycles = 0;
  logic    calm;

  least_squares_line_fit_energy u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .point_i(point_i), .done_o(done_o), .result_o(result_o)
  );

  lslfe_checker #(.MAX_POINTS(MaxPts)) u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .point_i(point_i), .done_o(done_o), .result_o(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one point beat, preceded now and then by an idle burst
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start   <= 1;
    point_i <= '{x_coord: x, y_coord: y, last_point: last};
    do @(posedge clk_i); while (busy);
    n_items++;
    if (last) n_sets++;
  endtask

  task automatic send_set(int cnt, int mode);
    logic [15:0] x, y;
    int          a, b;
    a = $urandom_range(0, 40) - 20;
    b = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < cnt; i++) begin
      case (mode)
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin
          x = 16'($urandom_range(0, 1000) - 500);
          y = 16'(a * $signed(x) + b + int'($urandom_range(0, 20)) - 10);
        end
        default: begin x = 16'd77; y = 16'($urandom); end
      endcase
      send_point(x, y, i == cnt - 1);
    end
  endtask

  initial begin
    start = 0; point_i = '0; rst_ni = 0; calm = 0;
    n_items = 0; n_sets = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // single point: too few, line kept at zero
    send_point(16'h8000, 16'h7fff, 1);
    // two equal x: vertical set
    send_point(16'h7fff, 16'h0001, 0);
    send_point(16'h7fff, 16'h8000, 1);
    // steep line saturates slope; intercept lands on its most negative value
    send_point(16'h0000, 16'h8000, 0);
    send_point(16'h0001, 16'h7fff, 1);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7fff, 16'h7fff, 1);
    send_point(16'hffff, 16'h0000, 0);
    send_point(16'h0000, 16'hffff, 0);
    send_point(16'h0001, 16'h0001, 1);
    // single point keeps the line of the previous set
    send_point(16'h1234, 16'hedcb, 1);
    // store overflow, last point dropped too
    send_set(MaxPts + 3, 0);
    // hold off until the block has delivered everything
    start <= 0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    while (n_items < 1280) begin
      int k;
      k = $urandom_range(0, 99);
      if (n_items > 1050) calm = 1;
      if (k < 55) send_set($urandom_range(2, 12), 1);
      else if (k < 85) send_set($urandom_range(1, 10), 0);
      else if (k < 95) send_set($urandom_range(1, 5), 2);
      else if (k < 97) send_set($urandom_range(60, 255), 1);
      else send_point(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    end
    send_set(MaxPts, 1);
    send_point(16'h0005, 16'h0006, 1);
    start <= 0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d point beats in %0d sets:", n_items, n_sets);
    $display("few, vertical, saturated, overflow and full sets, with idle gaps.");
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
